// ===== sv/plsf_pkg.sv =====
// Shared constants and types for the polynomial least-squares fit block.
// Used by every module of the block; depends on nothing.
package plsf_pkg;

  localparam int DEGREE_DEF     = 2;
  localparam int MAX_POINTS_DEF = 65536;

  localparam int X_W    = 12;
  localparam int Y_W    = 12;
  localparam int SUM_W  = 64;
  localparam int COEF_W = 64;
  localparam int IDX_W  = 3;
  localparam int FRAC_W = 32;

  // Exact integer width of the solver; no intermediate value of the
  // elimination comes close to it.
  localparam int BIG_W = 768;

  // Depth of the queue between accumulator and solver.
  localparam int QDEPTH = 2;

  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } alu_req_t;

endpackage

// ===== sv/polynomial_least_squares_fit.sv =====
// Points are taken one per cycle while full is low; a last point holds off input until
// its sums reach the queue. The solve is sequential: each wide multiply or divide runs
// in the bit-serial unit, about 36 of them at DEGREE 2. Each coefficient waits on its own
// final divide; after a zero pivot the zero coefficients leave without a divide, each
// once the one before is taken. A synchronous rst empties both queues and clears the
// sums and point count.
module polynomial_least_squares_fit #(
  parameter int DEGREE     = plsf_pkg::DEGREE_DEF,
  parameter int MAX_POINTS = plsf_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [plsf_pkg::X_W-1:0]           point_x,
  input  logic [plsf_pkg::Y_W-1:0]           point_y,
  input  logic                               last_point,
  output logic                               empty,
  input  logic                               pop,
  output logic [plsf_pkg::IDX_W-1:0]         coeff_index,
  output logic signed [plsf_pkg::COEF_W-1:0] coeff_value,
  output logic                               last_coeff,
  output logic                               singular,
  output logic                               overflow
);

  localparam int NSUMS = 2 * DEGREE + 1;
  localparam int NCOEF = DEGREE + 1;
  localparam int PS_W  = NSUMS * plsf_pkg::SUM_W;
  localparam int WS_W  = NCOEF * plsf_pkg::SUM_W;
  localparam int QW    = PS_W + WS_W + 1;

  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_empty;
  logic [PS_W-1:0]            f_ps;
  logic [WS_W-1:0]            f_ws;
  logic                       f_ovf;
  logic [QW-1:0]              q_head;
  plsf_pkg::alu_req_t         alu_req;
  logic [plsf_pkg::BIG_W-1:0] alu_a;
  logic [plsf_pkg::BIG_W-1:0] alu_b;
  logic                       alu_done;
  logic [plsf_pkg::BIG_W-1:0] alu_res;

  plsf_front #(.DEGREE(DEGREE), .MAX_POINTS(MAX_POINTS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .point_x(point_x), .point_y(point_y), .last_point(last_point),
    .q_push(q_push), .q_ps(f_ps), .q_ws(f_ws), .q_ovf(f_ovf), .q_full(q_full)
  );

  plsf_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .wr_en(q_push), .wr_data({f_ovf, f_ws, f_ps}),
    .full(q_full), .rd_en(q_pop), .rd_data(q_head), .empty(q_empty)
  );

  plsf_solver #(.DEGREE(DEGREE)) u_solver (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_pop(q_pop),
    .q_ps(q_head[PS_W-1:0]), .q_ws(q_head[PS_W +: WS_W]), .q_ovf(q_head[QW-1]),
    .alu_req(alu_req), .alu_a(alu_a), .alu_b(alu_b),
    .alu_done(alu_done), .alu_res(alu_res),
    .empty(empty), .pop(pop), .coeff_index(coeff_index),
    .coeff_value(coeff_value), .last_coeff(last_coeff),
    .singular(singular), .overflow(overflow)
  );

  plsf_alu u_alu (
    .clk(clk), .rst(rst), .req(alu_req), .a(alu_a), .b(alu_b),
    .done(alu_done), .res(alu_res)
  );

endmodule

// ===== sv/plsf_front.sv =====
// Point accumulator: a pipeline of power stages that builds the power sums
// and hands a snapshot of them to the solve queue on the last point.
// Depends on plsf_pkg.
module plsf_front #(
  parameter int DEGREE     = plsf_pkg::DEGREE_DEF,
  parameter int MAX_POINTS = plsf_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [plsf_pkg::X_W-1:0]               point_x,
  input  logic [plsf_pkg::Y_W-1:0]               point_y,
  input  logic                                   last_point,
  output logic                                   q_push,
  output logic [(2*DEGREE+1)*plsf_pkg::SUM_W-1:0] q_ps,
  output logic [(DEGREE+1)*plsf_pkg::SUM_W-1:0]   q_ws,
  output logic                                   q_ovf,
  input  logic                                   q_full
);

  localparam int NSUMS = 2 * DEGREE + 1;
  localparam int NCOEF = DEGREE + 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SW    = plsf_pkg::SUM_W;

  logic                     v    [NSUMS];
  logic                     mk   [NSUMS];
  logic                     ct   [NSUMS];
  logic [plsf_pkg::X_W-1:0] px   [NSUMS];
  logic [plsf_pkg::Y_W-1:0] py   [NSUMS];
  logic [SW-1:0]            pw   [NSUMS];
  logic [SW-1:0]            ps   [NSUMS];
  logic [SW-1:0]            ws   [NCOEF];
  logic [SW-1:0]            snap_ps [NSUMS];
  logic [SW-1:0]            snap_ws [NCOEF];
  logic [SW-1:0]            ps_add  [NSUMS];
  logic [SW-1:0]            ws_add  [NCOEF];
  logic [CNT_W-1:0]         count;
  logic                     dropped;
  logic                     ovf_hold;
  logic                     flush;
  logic                     busy;
  logic                     accept;
  logic                     at_cap;

  assign accept = push & ~full;
  assign at_cap = (count >= CNT_W'(MAX_POINTS));

  // Only one set boundary travels the pipeline at a time.
  always_comb begin
    busy = flush;
    for (int s = 0; s < NSUMS; s++) busy = busy | (v[s] & mk[s]);
  end

  assign full = busy | q_full;

  always_comb begin
    for (int s = 0; s < NSUMS; s++) ps_add[s] = (v[s] & ct[s]) ? pw[s] : '0;
    for (int s = 0; s < NCOEF; s++)
      ws_add[s] = (v[s] & ct[s]) ? SW'(pw[s] * SW'(py[s])) : '0;
  end

  always_ff @(posedge clk) begin
    px[0] <= point_x;
    py[0] <= point_y;
    pw[0] <= SW'(1);
    ct[0] <= ~at_cap;
    for (int s = 1; s < NSUMS; s++) begin
      px[s] <= px[s-1];
      py[s] <= py[s-1];
      ct[s] <= ct[s-1];
      pw[s] <= SW'(pw[s-1] * SW'(px[s-1]));
    end
    for (int s = 0; s < NSUMS; s++)
      if (v[s] & mk[s]) snap_ps[s] <= ps[s] + ps_add[s];
    for (int s = 0; s < NCOEF; s++)
      if (v[s] & mk[s]) snap_ws[s] <= ws[s] + ws_add[s];

    if (rst) begin
      for (int s = 0; s < NSUMS; s++) begin
        v[s]  <= 1'b0;
        mk[s] <= 1'b0;
        ps[s] <= '0;
      end
      for (int s = 0; s < NCOEF; s++) ws[s] <= '0;
      count    <= '0;
      dropped  <= 1'b0;
      ovf_hold <= 1'b0;
      flush    <= 1'b0;
    end else begin
      v[0]  <= accept;
      mk[0] <= accept & last_point;
      for (int s = 1; s < NSUMS; s++) begin
        v[s]  <= v[s-1];
        mk[s] <= mk[s-1];
      end
      // Each stage closes its sum as the set boundary passes it.
      for (int s = 0; s < NSUMS; s++)
        ps[s] <= (v[s] & mk[s]) ? '0 : ps[s] + ps_add[s];
      for (int s = 0; s < NCOEF; s++)
        ws[s] <= (v[s] & mk[s]) ? '0 : ws[s] + ws_add[s];
      flush <= v[NSUMS-1] & mk[NSUMS-1];
      if (accept) begin
        if (last_point) begin
          ovf_hold <= dropped | at_cap;
          dropped  <= 1'b0;
          count    <= '0;
        end else if (at_cap) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NSUMS; s++) q_ps[s*SW +: SW] = snap_ps[s];
    for (int s = 0; s < NCOEF; s++) q_ws[s*SW +: SW] = snap_ws[s];
  end

  assign q_push = flush;
  assign q_ovf  = ovf_hold;

endmodule

// ===== sv/plsf_queue.sv =====
// Short queue that carries finished power-sum sets to the solver.
// Depends on plsf_pkg for its depth.
module plsf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int DEPTH = plsf_pkg::QDEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_wr & ~do_rd) fill <= fill + CW'(1);
      else if (do_rd & ~do_wr) fill <= fill - CW'(1);
    end
  end

endmodule

// ===== sv/plsf_alu.sv =====
// Exact wide-integer unit: signed multiply by shift-and-add and signed
// truncating divide by restoring division, one bit per cycle; a zero divisor gives zero.
// Depends on plsf_pkg.
module plsf_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  plsf_pkg::alu_req_t         req,
  input  logic [plsf_pkg::BIG_W-1:0] a,
  input  logic [plsf_pkg::BIG_W-1:0] b,
  output logic                       done,
  output logic [plsf_pkg::BIG_W-1:0] res
);

  localparam int W   = plsf_pkg::BIG_W;
  localparam int CNW = $clog2(W + 1);

  logic           busy;
  logic [CNW-1:0] cnt;
  logic           op_r;
  logic           neg;
  logic           zdiv;
  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic [W-1:0]   acc;
  logic [W-1:0]   rem_sh;
  logic [W:0]     diff;
  logic [W-1:0]   mag;

  assign rem_sh = {acc[W-2:0], ma[W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, mb};
  assign mag    = (op_r == plsf_pkg::ALU_MUL) ? acc : ma;

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      neg  <= a[W-1] ^ b[W-1];
      zdiv <= (b == '0);
      ma   <= a[W-1] ? (~a + W'(1)) : a;
      mb   <= b[W-1] ? (~b + W'(1)) : b;
      acc  <= '0;
    end else if (busy && cnt != '0) begin
      if (op_r == plsf_pkg::ALU_MUL) begin
        acc <= {acc[W-2:0], 1'b0} + (ma[W-1] ? mb : '0);
        ma  <= {ma[W-2:0], 1'b0};
      end else begin
        // The quotient bits shift into the dividend register from below.
        acc <= diff[W] ? rem_sh : diff[W-1:0];
        ma  <= {ma[W-2:0], ~diff[W]};
      end
    end
    if (busy && cnt == '0) begin
      if (op_r == plsf_pkg::ALU_DIV && zdiv) res <= '0;
      else res <= neg ? (~mag + W'(1)) : mag;
    end

    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNW'(W);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - CNW'(1);
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/plsf_solver.sv =====
// Solve sequencer: loads the normal equations, runs fraction-free
// elimination and back substitution through the wide unit, and holds the
// output register for coefficients. Depends on plsf_pkg.
module plsf_solver #(
  parameter int DEGREE = plsf_pkg::DEGREE_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_empty,
  output logic                                    q_pop,
  input  logic [(2*DEGREE+1)*plsf_pkg::SUM_W-1:0] q_ps,
  input  logic [(DEGREE+1)*plsf_pkg::SUM_W-1:0]   q_ws,
  input  logic                                    q_ovf,
  output plsf_pkg::alu_req_t                      alu_req,
  output logic [plsf_pkg::BIG_W-1:0]              alu_a,
  output logic [plsf_pkg::BIG_W-1:0]              alu_b,
  input  logic                                    alu_done,
  input  logic [plsf_pkg::BIG_W-1:0]              alu_res,
  output logic                                    empty,
  input  logic                                    pop,
  output logic [plsf_pkg::IDX_W-1:0]              coeff_index,
  output logic signed [plsf_pkg::COEF_W-1:0]      coeff_value,
  output logic                                    last_coeff,
  output logic                                    singular,
  output logic                                    overflow
);

  localparam int NCOEF     = DEGREE + 1;
  localparam int MEM_DEPTH = NCOEF * (NCOEF + 1) + NCOEF;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int W         = plsf_pkg::BIG_W;
  localparam int SW        = plsf_pkg::SUM_W;
  localparam int CW        = plsf_pkg::COEF_W;
  localparam int IW        = plsf_pkg::IDX_W;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_LOAD   = 5'd1;
  localparam logic [4:0] ST_PIV_RD = 5'd2;
  localparam logic [4:0] ST_PIV    = 5'd3;
  localparam logic [4:0] ST_E_A    = 5'd4;
  localparam logic [4:0] ST_E_B    = 5'd5;
  localparam logic [4:0] ST_E_C    = 5'd6;
  localparam logic [4:0] ST_E_D    = 5'd7;
  localparam logic [4:0] ST_E_E    = 5'd8;
  localparam logic [4:0] ST_E_F    = 5'd9;
  localparam logic [4:0] ST_E_G    = 5'd10;
  localparam logic [4:0] ST_E_H    = 5'd11;
  localparam logic [4:0] ST_E_I    = 5'd12;
  localparam logic [4:0] ST_B_A    = 5'd13;
  localparam logic [4:0] ST_B_B    = 5'd14;
  localparam logic [4:0] ST_B_C    = 5'd15;
  localparam logic [4:0] ST_B_D    = 5'd16;
  localparam logic [4:0] ST_B_E    = 5'd17;
  localparam logic [4:0] ST_B_F    = 5'd18;
  localparam logic [4:0] ST_B_G    = 5'd19;
  localparam logic [4:0] ST_B_H    = 5'd20;
  localparam logic [4:0] ST_B_I    = 5'd21;
  localparam logic [4:0] ST_B_J    = 5'd22;
  localparam logic [4:0] ST_F_A    = 5'd23;
  localparam logic [4:0] ST_F_B    = 5'd24;
  localparam logic [4:0] ST_F_C    = 5'd25;
  localparam logic [4:0] ST_F_D    = 5'd26;
  localparam logic [4:0] ST_ZERO   = 5'd27;

  logic [4:0]    state;
  logic [IW-1:0] k;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [IW-1:0] li;
  logic [IW-1:0] lj;
  logic [W-1:0]  pivot;
  logic [W-1:0]  prev;
  logic [W-1:0]  det;
  logic [W-1:0]  acc;
  logic [W-1:0]  hold;
  logic [CW-1:0] coef;
  logic          ovf;

  logic [W-1:0]  mem [MEM_DEPTH];
  logic [W-1:0]  rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic          we;
  logic          out_valid;
  logic          load_done;

  function automatic logic [AW-1:0] mat_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    mat_addr = AW'(int'(r) * (NCOEF + 1) + int'(c));
  endfunction

  function automatic logic [AW-1:0] sol_addr(input logic [IW-1:0] r);
    sol_addr = AW'(NCOEF * (NCOEF + 1) + int'(r));
  endfunction

  // Clamp an exact value to the signed 64-bit coefficient range.
  function automatic logic [CW-1:0] sat64(input logic [W-1:0] val);
    logic [W-CW:0] upper;
    upper = val[W-1:CW-1];
    if (upper == '0 || upper == '1) sat64 = val[CW-1:0];
    else if (val[W-1]) sat64 = {1'b1, {(CW-1){1'b0}}};
    else sat64 = {1'b0, {(CW-1){1'b1}}};
  endfunction

  assign load_done = (lj == IW'(NCOEF)) && (li == IW'(DEGREE));
  assign q_pop     = (state == ST_LOAD) && load_done;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    raddr   = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    alu_req = '0;
    alu_a   = '0;
    alu_b   = '0;
    unique case (state)
      ST_LOAD: begin
        we    = 1'b1;
        waddr = mat_addr(li, lj);
        if (lj == IW'(NCOEF)) wdata = W'(q_ws[SW*int'(li) +: SW]);
        else wdata = W'(q_ps[SW*(int'(li) + int'(lj)) +: SW]);
      end
      ST_PIV_RD: raddr = mat_addr(k, k);
      ST_E_A:    raddr = mat_addr(i, j);
      ST_E_B: begin
        alu_req = '{start: 1'b1, op: plsf_pkg::ALU_MUL};
        alu_a   = pivot;
        alu_b   = rdata;
      end
      ST_E_D:    raddr = mat_addr(i, k);
      ST_E_E:    raddr = mat_addr(k, j);
      ST_E_F: begin
        alu_req = '{start: 1'b1, op: plsf_pkg::ALU_MUL};
        alu_a   = hold;
        alu_b   = rdata;
      end
      ST_E_H: begin
        alu_req = '{start: 1'b1, op: plsf_pkg::ALU_DIV};
        alu_a   = acc;
        alu_b   = prev;
      end
      ST_E_I: begin
        we    = alu_done;
        waddr = mat_addr(i, j);
        wdata = alu_res;
      end
      ST_B_A:    raddr = mat_addr(i, IW'(NCOEF));
      ST_B_B: begin
        alu_req = '{start: 1'b1, op: plsf_pkg::ALU_MUL};
        alu_a   = rdata;
        alu_b   = det;
      end
      ST_B_D:    raddr = mat_addr(i, j);
      ST_B_E:    raddr = sol_addr(j);
      ST_B_F: begin
        alu_req = '{start: 1'b1, op: plsf_pkg::ALU_MUL};
        alu_a   = hold;
        alu_b   = rdata;
      end
      ST_B_H:    raddr = mat_addr(i, i);
      ST_B_I: begin
        alu_req = '{start: 1'b1, op: plsf_pkg::ALU_DIV};
        alu_a   = acc;
        alu_b   = rdata;
      end
      ST_B_J: begin
        we    = alu_done;
        waddr = sol_addr(i);
        wdata = alu_res;
      end
      ST_F_A:    raddr = sol_addr(i);
      ST_F_B: begin
        alu_req = '{start: 1'b1, op: plsf_pkg::ALU_DIV};
        alu_a   = {rdata[W-plsf_pkg::FRAC_W-1:0], {plsf_pkg::FRAC_W{1'b0}}};
        alu_b   = det;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      i         <= '0;
      j         <= '0;
      li        <= '0;
      lj        <= '0;
    end else begin
      if (out_valid && pop) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          li <= '0;
          lj <= '0;
          if (!q_empty) state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (lj == IW'(NCOEF)) begin
            lj <= '0;
            li <= li + IW'(1);
            if (load_done) begin
              ovf   <= q_ovf;
              prev  <= W'(1);
              k     <= '0;
              state <= ST_PIV_RD;
            end
          end else begin
            lj <= lj + IW'(1);
          end
        end
        ST_PIV_RD: state <= ST_PIV;
        ST_PIV: begin
          pivot <= rdata;
          if (rdata == '0) begin
            i     <= '0;
            state <= ST_ZERO;
          end else if (k == IW'(DEGREE)) begin
            det   <= rdata;
            i     <= IW'(DEGREE);
            state <= ST_B_A;
          end else begin
            i     <= k + IW'(1);
            j     <= k + IW'(1);
            state <= ST_E_A;
          end
        end
        ST_E_A: state <= ST_E_B;
        ST_E_B: state <= ST_E_C;
        ST_E_C: if (alu_done) begin
          acc   <= alu_res;
          state <= ST_E_D;
        end
        ST_E_D: state <= ST_E_E;
        ST_E_E: begin
          hold  <= rdata;
          state <= ST_E_F;
        end
        ST_E_F: state <= ST_E_G;
        ST_E_G: if (alu_done) begin
          acc   <= acc - alu_res;
          state <= ST_E_H;
        end
        ST_E_H: state <= ST_E_I;
        ST_E_I: if (alu_done) begin
          if (j == IW'(NCOEF)) begin
            j <= k + IW'(1);
            if (i == IW'(DEGREE)) begin
              prev  <= pivot;
              k     <= k + IW'(1);
              state <= ST_PIV_RD;
            end else begin
              i     <= i + IW'(1);
              state <= ST_E_A;
            end
          end else begin
            j     <= j + IW'(1);
            state <= ST_E_A;
          end
        end
        ST_B_A: state <= ST_B_B;
        ST_B_B: state <= ST_B_C;
        ST_B_C: if (alu_done) begin
          acc   <= alu_res;
          j     <= i + IW'(1);
          state <= ST_B_D;
        end
        ST_B_D: state <= (j == IW'(NCOEF)) ? ST_B_H : ST_B_E;
        ST_B_E: begin
          hold  <= rdata;
          state <= ST_B_F;
        end
        ST_B_F: state <= ST_B_G;
        ST_B_G: if (alu_done) begin
          acc   <= acc - alu_res;
          j     <= j + IW'(1);
          state <= ST_B_D;
        end
        ST_B_H: state <= ST_B_I;
        ST_B_I: state <= ST_B_J;
        ST_B_J: if (alu_done) begin
          if (i == '0) begin
            state <= ST_F_A;
          end else begin
            i     <= i - IW'(1);
            state <= ST_B_A;
          end
        end
        ST_F_A: state <= ST_F_B;
        ST_F_B: state <= ST_F_C;
        ST_F_C: if (alu_done) begin
          coef  <= sat64(alu_res);
          state <= ST_F_D;
        end
        ST_F_D: if (!out_valid) begin
          out_valid   <= 1'b1;
          coeff_index <= i;
          coeff_value <= coef;
          last_coeff  <= (i == IW'(DEGREE));
          singular    <= 1'b0;
          overflow    <= ovf;
          i           <= i + IW'(1);
          state       <= (i == IW'(DEGREE)) ? ST_IDLE : ST_F_A;
        end
        ST_ZERO: if (!out_valid) begin
          out_valid   <= 1'b1;
          coeff_index <= i;
          coeff_value <= '0;
          last_coeff  <= (i == IW'(DEGREE));
          singular    <= 1'b1;
          overflow    <= ovf;
          i           <= i + IW'(1);
          if (i == IW'(DEGREE)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign empty = ~out_valid;

endmodule

// ===== sv/plsf_checker.sv =====
// Port-level checks on the coefficient output of the fit block, and the
// bind that attaches them to the top level. Depends on plsf_pkg.
module plsf_checker #(
  parameter int DEGREE = plsf_pkg::DEGREE_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               empty,
  input logic                               pop,
  input logic [plsf_pkg::IDX_W-1:0]         coeff_index,
  input logic signed [plsf_pkg::COEF_W-1:0] coeff_value,
  input logic                               last_coeff,
  input logic                               singular
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(coeff_value) && $stable(coeff_index)))
    else $error("waiting coefficient changed before it was taken");

  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_coeff == (coeff_index == plsf_pkg::IDX_W'(DEGREE))))
    else $error("last_coeff does not match the highest power");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && singular) |-> (coeff_value == '0))
    else $error("singular result carries a nonzero coefficient");

endmodule

bind polynomial_least_squares_fit plsf_checker #(.DEGREE(DEGREE)) u_plsf_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .coeff_index(coeff_index),
  .coeff_value(coeff_value), .last_coeff(last_coeff), .singular(singular)
);

// ===== tb/sv/tb_polynomial_least_squares_fit.sv =====
// Testbench for polynomial_least_squares_fit: drives point sets and checks the fitted
// coefficients against an exact wide-integer solve of the normal equations.
// Depends on plsf_pkg and the polynomial_least_squares_fit RTL.
module tb_polynomial_least_squares_fit;

  localparam int X_W    = plsf_pkg::X_W;
  localparam int Y_W    = plsf_pkg::Y_W;
  localparam int SUM_W  = plsf_pkg::SUM_W;
  localparam int COEF_W = plsf_pkg::COEF_W;
  localparam int IDX_W  = plsf_pkg::IDX_W;
  localparam int FRAC_W = plsf_pkg::FRAC_W;
  localparam int BIG_W  = plsf_pkg::BIG_W;

  localparam int DEG     = plsf_pkg::DEGREE_DEF;
  localparam int NCOEF   = DEG + 1;
  localparam int NSUMS   = 2 * DEG + 1;
  localparam int MAX_PTS = plsf_pkg::MAX_POINTS_DEF;

  typedef logic signed [BIG_W-1:0] wide_t;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] value;
    logic                     is_last;
    logic                     sing;
    logic                     ovf;
  } coeff_t;

  class fit_scoreboard;
    logic [SUM_W-1:0] xsum[NSUMS];
    logic [SUM_W-1:0] xysum[NCOEF];
    int               count;
    bit               dropped;
    coeff_t           pending[$];
    int               errors;
    int               sets;
    int               singular_sets;
    int               dropped_sets;

    function void clear_sums();
      foreach (xsum[k]) xsum[k] = '0;
      foreach (xysum[k]) xysum[k] = '0;
      count = 0;
      dropped = 0;
    endfunction

    function void init();
      clear_sums();
      errors = 0;
      sets = 0;
      singular_sets = 0;
      dropped_sets = 0;
    endfunction

    function logic signed [COEF_W-1:0] saturate(wide_t v);
      wide_t hi, lo;
      hi = wide_t'(64'sh7FFF_FFFF_FFFF_FFFF);
      lo = -hi - 1;
      if (v > hi) return hi[COEF_W-1:0];
      if (v < lo) return lo[COEF_W-1:0];
      return v[COEF_W-1:0];
    endfunction

    // Fraction-free elimination, then back substitution scaled by the determinant.
    function bit solve_fit(output logic signed [COEF_W-1:0] coef[NCOEF]);
      wide_t m[NCOEF][NCOEF+1];
      wide_t scaled[NCOEF];
      wide_t prev, t1, t2, det;
      for (int i = 0; i < NCOEF; i++) begin
        for (int j = 0; j < NCOEF; j++) m[i][j] = wide_t'({1'b0, xsum[i+j]});
        m[i][NCOEF] = wide_t'({1'b0, xysum[i]});
      end
      prev = 1;
      for (int k = 0; k < NCOEF - 1; k++) begin
        if (m[k][k] == 0) return 1;
        for (int i = k + 1; i < NCOEF; i++) begin
          for (int j = k + 1; j <= NCOEF; j++) begin
            t1 = m[k][k] * m[i][j] - m[i][k] * m[k][j];
            m[i][j] = t1 / prev;
          end
          m[i][k] = 0;
        end
        prev = m[k][k];
      end
      det = m[NCOEF-1][NCOEF-1];
      if (det == 0) return 1;
      for (int i = NCOEF - 1; i >= 0; i--) begin
        t1 = m[i][NCOEF] * det;
        for (int j = i + 1; j < NCOEF; j++) begin
          t2 = m[i][j] * scaled[j];
          t1 = t1 - t2;
        end
        scaled[i] = t1 / m[i][i];
      end
      for (int i = 0; i < NCOEF; i++) coef[i] = saturate((scaled[i] <<< FRAC_W) / det);
      return 0;
    endfunction

    function void note_point(logic [X_W-1:0] x, logic [Y_W-1:0] y, logic last);
      logic [SUM_W-1:0] p;
      logic signed [COEF_W-1:0] coef[NCOEF];
      coeff_t e;
      bit sing;
      if (count >= MAX_PTS) begin
        dropped = 1;
      end else begin
        p = 1;
        for (int k = 0; k < NSUMS; k++) begin
          xsum[k] += p;
          if (k < NCOEF) xysum[k] += p * SUM_W'(y);
          p = p * SUM_W'(x);
        end
        count++;
      end
      if (!last) return;
      sing = solve_fit(coef);
      for (int k = 0; k < NCOEF; k++) begin
        e.idx = IDX_W'(k);
        e.value = sing ? '0 : coef[k];
        e.is_last = (k == DEG);
        e.sing = sing;
        e.ovf = dropped;
        pending = {pending, e};
      end
      sets++;
      if (sing) singular_sets++;
      if (dropped) dropped_sets++;
      clear_sums();
    endfunction

    function void check_coeff(coeff_t got);
      coeff_t e;
      if (pending.size() == 0) begin
        $error("coefficient %0d arrived with none expected", got.idx);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.idx !== e.idx) begin
        $error("coeff_index: expected %0d, got %0d", e.idx, got.idx);
        errors++;
      end
      if (got.value !== e.value) begin
        $error("coeff_value: expected %0d, got %0d", e.value, got.value);
        errors++;
      end
      if (got.is_last !== e.is_last) begin
        $error("last_coeff: expected %0b, got %0b", e.is_last, got.is_last);
        errors++;
      end
      if (got.sing !== e.sing) begin
        $error("singular: expected %0b, got %0b", e.sing, got.sing);
        errors++;
      end
      if (got.ovf !== e.ovf) begin
        $error("overflow: expected %0b, got %0b", e.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     push;
  logic                     full;
  logic [X_W-1:0]           point_x;
  logic [Y_W-1:0]           point_y;
  logic                     last_point;
  logic                     empty;
  logic                     pop;
  logic [IDX_W-1:0]         coeff_index;
  logic signed [COEF_W-1:0] coeff_value;
  logic                     last_coeff;
  logic                     singular;
  logic                     overflow;

  fit_scoreboard fits;
  bit            hold_request;
  bit            stimulus_done;

  polynomial_least_squares_fit #(
    .DEGREE(DEG),
    .MAX_POINTS(MAX_PTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .point_x(point_x),
    .point_y(point_y),
    .last_point(last_point),
    .empty(empty),
    .pop(pop),
    .coeff_index(coeff_index),
    .coeff_value(coeff_value),
    .last_coeff(last_coeff),
    .singular(singular),
    .overflow(overflow)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one point and waits until the block takes it.
  task automatic send_point(logic [X_W-1:0] x, logic [Y_W-1:0] y, logic last, bit idle);
    int gap;
    push <= 1'b1;
    point_x <= x;
    point_y <= y;
    last_point <= last;
    do @(posedge clk); while (full);
    fits.note_point(x, y, last);
    gap = idle ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_set(int npts, int xlo, int xhi, bit idle);
    for (int i = 0; i < npts; i++)
      send_point(X_W'($urandom_range(xlo, xhi)), Y_W'($urandom_range(0, 4095)),
                 i == npts - 1, idle);
  endtask

  // Result side: pops at random, with one long hold-off when asked.
  initial begin
    coeff_t got;
    int gap;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        pop <= 1'b0;
        repeat (90000) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0 && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (pop && !empty) begin
        got.idx = coeff_index;
        got.value = coeff_value;
        got.is_last = last_coeff;
        got.sing = singular;
        got.ovf = overflow;
        fits.check_coeff(got);
      end
    end
  end

  initial begin
    int n;
    fits = new();
    fits.init();
    hold_request = 0;
    stimulus_done = 0;
    rst = 1'b1;
    push = 1'b0;
    point_x = '0;
    point_y = '0;
    last_point = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner values of both coordinates.
    send_point(12'd0, 12'd0, 1'b0, 0);
    send_point(12'd4095, 12'd4095, 1'b0, 0);
    send_point(12'd4095, 12'd0, 1'b0, 0);
    send_point(12'd0, 12'd4095, 1'b0, 0);
    send_point(12'd2048, 12'd1365, 1'b1, 0);
    // A single point cannot define a parabola.
    send_point(12'd100, 12'd200, 1'b1, 0);
    // Repeated x gives a zero pivot.
    send_point(12'd77, 12'd1, 1'b0, 0);
    send_point(12'd77, 12'd4000, 1'b1, 0);
    // A steep parabola far from the origin saturates the constant term.
    send_point(12'd4093, 12'd0, 1'b0, 0);
    send_point(12'd4095, 12'd4095, 1'b0, 0);
    send_point(12'd4094, 12'd0, 1'b1, 0);

    // The receiver stalls for a long stretch while sets keep coming.
    hold_request = 1;
    n = 0;
    while (n < 300) begin
      int sz;
      int r;
      r = $urandom_range(0, 99);
      sz = $urandom_range(3, 14);
      if (r < 70) send_set(sz, 0, 4095, 1);
      else if (r < 80) send_set(sz, 4000, 4095, 1);
      else if (r < 88) send_set(sz, 0, 3, 1);
      else if (r < 94) begin
        sz = $urandom_range(1, 2);
        send_set(sz, 0, 4095, 1);
      end else begin
        sz = $urandom_range(15, 30);
        send_set(sz, 0, 4095, 1);
      end
      n += sz;
    end
    push <= 1'b0;

    while (fits.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d point sets: %0d singular, %0d with dropped points.",
             fits.sets, fits.singular_sets, fits.dropped_sets);
    if (fits.errors == 0) begin
      $display("polynomial_least_squares_fit: match");
    end else begin
      $display("polynomial_least_squares_fit: mismatch");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("Run timed out.");
    $display("polynomial_least_squares_fit: mismatch");
    $finish;
  end

endmodule
